### rtl/kct_pkg.sv
// Shared types and constants for the keyed count table.
package kct_pkg;

  // Fixed field widths of the beats
  localparam int OP_W     = 2;
  localparam int AMOUNT_W = 32;
  localparam int STATUS_W = 4;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Operation codes
  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;
  localparam op_t OP_UNUSED = 2'd3;

  // Result status codes
  localparam status_t ST_NEW       = 4'd0;
  localparam status_t ST_INC       = 4'd1;
  localparam status_t ST_DEC       = 4'd2;
  localparam status_t ST_REMOVED   = 4'd3;
  localparam status_t ST_NOT_FOUND = 4'd4;
  localparam status_t ST_FULL      = 4'd5;
  localparam status_t ST_BAD_KEY   = 4'd6;
  localparam status_t ST_IGNORED   = 4'd7;
  localparam status_t ST_CLEARED   = 4'd8;

endpackage

### rtl/kct_in_if.sv
// Request channel: operation, key and amount with valid/ready.
interface kct_in_if import kct_pkg::*; #(
  parameter int KEY_BITS = 16
);
  logic                       valid;
  logic                       ready;
  op_t                        operation;
  logic [KEY_BITS-1:0]        key_tag;
  logic signed [AMOUNT_W-1:0] amount;

  modport source (output valid, operation, key_tag, amount, input ready);
  modport sink   (input valid, operation, key_tag, amount, output ready);
endinterface

### rtl/kct_out_if.sv
// Result channel: status, count after the step and saturation flag.
interface kct_out_if import kct_pkg::*; #(
  parameter int COUNT_BITS = 31
);
  logic                  valid;
  logic                  ready;
  status_t               status;
  logic [COUNT_BITS-1:0] count_after;
  logic                  saturated;

  modport source (output valid, status, count_after, saturated, input ready);
  modport sink   (input valid, status, count_after, saturated, output ready);
endinterface

### rtl/keyed_count_table.sv
// Keyed count table: scan-based key lookup with add, remove and clear.
//
//   channel  dir  handshake            beat contents
//   in_ch    in   in_ch.valid/ready    operation, key_tag, amount
//   out_ch   out  out_ch.valid/ready   status, count_after, saturated
//
// Add and remove scan the table from entry 0 and stop early when the key
// hits; the scan reads one key/count entry per cycle through the single read
// port of the table memories. Clear, invalid key and unused operation skip
// the scan and go straight to loading the output register.
// rst_n (synchronous) empties the table at once; no clearing pass is needed.
// A finished result waits in the output register, and the next beat is taken
// while it waits; the result after that waits until out_ch.ready.
module keyed_count_table import kct_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int KEY_BITS      = 16,
  parameter int COUNT_BITS    = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  kct_in_if.sink    in_ch,
  kct_out_if.source out_ch
);

  localparam int IW    = $clog2(TABLE_ENTRIES);
  localparam int AMT_W = AMOUNT_W - 1;
  // Wide enough for count + amount without overflow
  localparam int WB    = ((COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W) + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  // Table memories, one write and one read port each
  logic [KEY_BITS-1:0]   key_mem [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [TABLE_ENTRIES];
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [KEY_BITS-1:0]   mem_wkey;
  logic [COUNT_BITS-1:0] mem_wcnt;
  logic [KEY_BITS-1:0]   key_q_r;
  logic [COUNT_BITS-1:0] cnt_q_r;

  logic [1:0]               state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] used_r, used_nxt;
  logic [IW-1:0]            rd_addr_r, rd_addr_nxt;
  logic                     issue_done_r, issue_done_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]            cmp_idx_r, cmp_idx_nxt;
  op_t                      op_r, op_nxt;
  logic [KEY_BITS-1:0]      key_r, key_nxt;
  logic [AMT_W-1:0]         amt_r, amt_nxt;
  logic                     pos_r, pos_nxt;
  logic                     hit_r, hit_nxt;
  logic [IW-1:0]            hit_idx_r, hit_idx_nxt;
  logic [COUNT_BITS-1:0]    hit_cnt_r, hit_cnt_nxt;
  logic                     free_found_r, free_found_nxt;
  logic [IW-1:0]            free_idx_r, free_idx_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic [COUNT_BITS-1:0]    res_count_r, res_count_nxt;
  logic                     res_sat_r, res_sat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [COUNT_BITS-1:0]    out_count_r, out_count_nxt;
  logic                     out_sat_r, out_sat_nxt;

  // Shared arithmetic for the update step
  logic [WB-1:0] cnt_ext, amt_ext, max_ext, sum_w, diff_w;

  assign cnt_ext = WB'(hit_cnt_r);
  assign amt_ext = WB'(amt_r);
  assign max_ext = WB'({COUNT_BITS{1'b1}});
  assign sum_w   = cnt_ext + amt_ext;
  assign diff_w  = cnt_ext - amt_ext;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.count_after = out_count_r;
  assign out_ch.saturated   = out_sat_r;

  // Sequencer and datapath next values
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    rd_addr_nxt    = rd_addr_r;
    issue_done_nxt = issue_done_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = rd_addr_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    amt_nxt        = amt_r;
    pos_nxt        = pos_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_cnt_nxt    = hit_cnt_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    res_sat_nxt    = res_sat_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_sat_nxt    = out_sat_r;
    mem_we         = 1'b0;
    mem_waddr      = hit_idx_r;
    mem_wkey       = key_r;
    mem_wcnt       = '0;

    // Result beat taken downstream
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt         = in_ch.operation;
          key_nxt        = in_ch.key_tag;
          amt_nxt        = in_ch.amount[AMT_W-1:0];
          pos_nxt        = !in_ch.amount[AMOUNT_W-1] && (in_ch.amount != '0);
          rd_addr_nxt    = '0;
          issue_done_nxt = 1'b0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          res_count_nxt  = '0;
          res_sat_nxt    = 1'b0;
          state_nxt      = S_OUT;
          if (in_ch.operation == OP_CLEAR) begin
            used_nxt       = '0;
            res_status_nxt = ST_CLEARED;
          end else if (!(in_ch.operation inside {OP_ADD, OP_REMOVE})) begin
            res_status_nxt = ST_IGNORED;
          end else if (in_ch.key_tag == '0) begin
            res_status_nxt = ST_BAD_KEY;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle until the last entry
        if (!issue_done_r) begin
          cmp_vld_nxt = 1'b1;
          if (rd_addr_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            rd_addr_nxt = rd_addr_r + 1'b1;
          end
        end
        // Compare the entry read last cycle
        if (cmp_vld_r) begin
          if (!used_r[cmp_idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
          if (used_r[cmp_idx_r] && key_q_r == key_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = cmp_idx_r;
            hit_cnt_nxt = cnt_q_r;
            state_nxt   = S_UPD;
          end else if (cmp_idx_r == LAST_IDX) begin
            state_nxt = S_UPD;
          end
        end
      end

      S_UPD: begin
        res_count_nxt = '0;
        res_sat_nxt   = 1'b0;
        state_nxt     = S_OUT;
        if (!pos_r) begin
          res_status_nxt = ST_IGNORED;
          res_count_nxt  = hit_r ? hit_cnt_r : '0;
        end else if (op_r == OP_ADD) begin
          if (hit_r) begin
            res_status_nxt = ST_INC;
            mem_we         = 1'b1;
            mem_waddr      = hit_idx_r;
            if (sum_w > max_ext) begin
              res_sat_nxt = 1'b1;
              mem_wcnt    = {COUNT_BITS{1'b1}};
            end else begin
              mem_wcnt = sum_w[COUNT_BITS-1:0];
            end
            res_count_nxt = mem_wcnt;
          end else if (!free_found_r) begin
            res_status_nxt = ST_FULL;
          end else begin
            res_status_nxt         = ST_NEW;
            used_nxt[free_idx_r]   = 1'b1;
            mem_we                 = 1'b1;
            mem_waddr              = free_idx_r;
            if (amt_ext > max_ext) begin
              res_sat_nxt = 1'b1;
              mem_wcnt    = {COUNT_BITS{1'b1}};
            end else begin
              mem_wcnt = amt_ext[COUNT_BITS-1:0];
            end
            res_count_nxt = mem_wcnt;
          end
        end else begin
          // Remove
          if (!hit_r) begin
            res_status_nxt = ST_NOT_FOUND;
          end else if (cnt_ext <= amt_ext) begin
            res_status_nxt      = ST_REMOVED;
            used_nxt[hit_idx_r] = 1'b0;
          end else begin
            res_status_nxt = ST_DEC;
            mem_we         = 1'b1;
            mem_waddr      = hit_idx_r;
            mem_wcnt       = diff_w[COUNT_BITS-1:0];
            res_count_nxt  = mem_wcnt;
          end
        end
      end

      S_OUT: begin
        // Load the output register once it is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_count_nxt  = res_count_r;
          out_sat_nxt    = res_sat_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    issue_done_r <= issue_done_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    amt_r        <= amt_nxt;
    pos_r        <= pos_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_cnt_r    <= hit_cnt_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    res_sat_r    <= res_sat_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_sat_r    <= out_sat_nxt;
  end

  // Key and count memories: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wkey;
      cnt_mem[mem_waddr] <= mem_wcnt;
    end
    key_q_r <= key_mem[rd_addr_r];
    cnt_q_r <= cnt_mem[rd_addr_r];
  end

endmodule

### verif/tb_keyed_count_table.sv
// Testbench for keyed_count_table: self-checking add/remove/clear traffic.
module tb_keyed_count_table;
  import kct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES     = 16;
  localparam int KEY_W       = 16;
  localparam int COUNT_W     = 31;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 40;

  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count_after;
    logic               saturated;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  kct_in_if  #(.KEY_BITS(KEY_W))     in_ch ();
  kct_out_if #(.COUNT_BITS(COUNT_W)) out_ch ();

  keyed_count_table #(
    .TABLE_ENTRIES(ENTRIES),
    .KEY_BITS     (KEY_W),
    .COUNT_BITS   (COUNT_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the table
  logic               tbl_used  [ENTRIES];
  logic [KEY_W-1:0]   tbl_key   [ENTRIES];
  logic [COUNT_W-1:0] tbl_count [ENTRIES];

  reply_t table_replies[$];
  reply_t want_reply;
  int     err_count   = 0;
  int     beats_sent  = 0;
  int     idle_cycles = 0;
  int     send_gap_pct;
  int     recv_gap_pct;

  always #6 clk = ~clk;

  // Used slot holding key, -1 when absent
  function automatic int find_entry(logic [KEY_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_used[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  // Apply one request to the shadow table and return the reply it produces
  function automatic reply_t table_apply(op_t op, logic [KEY_W-1:0] key, logic [31:0] amt);
    reply_t      r;
    int          hit;
    int          spot;
    logic        positive;
    logic [31:0] sum;
    r.status      = ST_IGNORED;
    r.count_after = '0;
    r.saturated   = 1'b0;
    positive      = (amt != 32'd0) && !amt[31];
    if (op == OP_CLEAR) begin
      for (int i = 0; i < ENTRIES; i++) tbl_used[i] = 1'b0;
      r.status = ST_CLEARED;
    end else if (op != OP_ADD && op != OP_REMOVE) begin
      r.status = ST_IGNORED;
    end else if (key == '0) begin
      r.status = ST_BAD_KEY;
    end else begin
      hit = find_entry(key);
      if (!positive) begin
        // zero or negative amount: report the present count only
        if (hit >= 0) r.count_after = tbl_count[hit];
      end else if (op == OP_ADD) begin
        if (hit >= 0) begin
          sum = {1'b0, tbl_count[hit]} + {1'b0, amt[30:0]};
          if (sum > {1'b0, COUNT_TOP}) begin
            sum         = {1'b0, COUNT_TOP};
            r.saturated = 1'b1;
          end
          tbl_count[hit] = sum[COUNT_W-1:0];
          r.status       = ST_INC;
          r.count_after  = sum[COUNT_W-1:0];
        end else begin
          // lowest free slot takes the new key
          spot = -1;
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!tbl_used[i]) spot = i;
          if (spot < 0) begin
            r.status = ST_FULL;
          end else begin
            tbl_used[spot]  = 1'b1;
            tbl_key[spot]   = key;
            tbl_count[spot] = amt[30:0];
            r.status        = ST_NEW;
            r.count_after   = amt[30:0];
          end
        end
      end else begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (tbl_count[hit] <= amt[30:0]) begin
          tbl_used[hit] = 1'b0;
          r.status      = ST_REMOVED;
        end else begin
          tbl_count[hit] = tbl_count[hit] - amt[30:0];
          r.status       = ST_DEC;
          r.count_after  = tbl_count[hit];
        end
      end
    end
    return r;
  endfunction

  // Mostly modest positive amounts, sometimes near the top of the range
  function automatic logic [31:0] pick_amount();
    if ($urandom_range(9) == 0) return $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
    return $urandom_range(4096, 1);
  endfunction

  // Key of a random used slot, or a random nonzero key
  function automatic logic [KEY_W-1:0] pick_held_key();
    int i;
    i = $urandom_range(ENTRIES - 1);
    if (tbl_used[i]) return tbl_key[i];
    return KEY_W'($urandom_range(16'hFFFF, 1));
  endfunction

  // Send one request beat; valid stays high when the next beat follows at once
  task automatic send_beat(op_t op, logic [KEY_W-1:0] key, logic [31:0] amt);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.key_tag   <= key;
    in_ch.amount    <= amt;
    do @(posedge clk); while (!in_ch.ready);
    table_replies.push_back(table_apply(op, key, amt));
    beats_sent++;
  endtask

  // Stop sending and wait for every outstanding reply
  task automatic wait_replies();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (table_replies.size() != 0);
  endtask

  // Edge values of every field and the hit and miss corners of the lookup
  task automatic test_directed();
    send_beat(OP_ADD,    16'h0000, 32'd100);
    send_beat(OP_REMOVE, 16'h0000, 32'd100);
    send_beat(OP_ADD,    16'h0005, 32'd0);
    send_beat(OP_ADD,    16'h0005, 32'hFFFF_FFFF);
    send_beat(OP_REMOVE, 16'h0005, 32'h8000_0000);
    send_beat(OP_REMOVE, 16'h0005, 32'd10);
    send_beat(OP_ADD,    16'h0005, 32'd256);
    send_beat(OP_ADD,    16'h0005, 32'h7FFF_FFFF);
    send_beat(OP_ADD,    16'h0005, 32'd1);
    send_beat(OP_ADD,    16'h0005, 32'hFFFF_FFFB);
    send_beat(OP_REMOVE, 16'h0005, 32'h7FFF_FFFE);
    send_beat(OP_REMOVE, 16'h0005, 32'd1);
    send_beat(OP_ADD,    16'hFFFF, 32'd1);
    send_beat(OP_REMOVE, 16'hFFFF, 32'd1000);
    send_beat(OP_ADD,    16'hAAAA, 32'h5555_5555);
    send_beat(OP_UNUSED, 16'hAAAA, 32'd7);
    send_beat(OP_CLEAR,  16'h1234, 32'hDEAD_BEEF);
    send_beat(OP_REMOVE, 16'hAAAA, 32'd1);
    send_beat(OP_ADD,    16'hAAAA, 32'd3);
    wait_replies();
  endtask

  // Add/remove traffic over a small key pool, with a little noise
  task automatic test_churn(int n);
    logic [KEY_W-1:0] pool [20];
    logic [KEY_W-1:0] key;
    logic [31:0]      amt;
    int               start;
    int               roll;
    int               hit;
    foreach (pool[i]) pool[i] = KEY_W'($urandom_range(16'hFFFF, 1));
    start = beats_sent;
    while (beats_sent - start < n) begin
      roll = $urandom_range(99);
      key  = pool[$urandom_range(19)];
      amt  = pick_amount();
      if (roll < 50) begin
        send_beat(OP_ADD, key, amt);
      end else if (roll < 90) begin
        hit = find_entry(key);
        // often remove exactly the count, one less, or more
        if (hit >= 0 && $urandom_range(2) == 0) begin
          case ($urandom_range(2))
            0: amt = {1'b0, tbl_count[hit]};
            1: amt = (tbl_count[hit] > 1) ? {1'b0, tbl_count[hit] - 1'b1} : 32'd1;
            default: amt = {1'b0, tbl_count[hit]} + $urandom_range(100, 1);
          endcase
          if (amt[31] || amt == 32'd0) amt = 32'd1;
        end
        send_beat(OP_REMOVE, key, amt);
      end else if (roll < 92) begin
        send_beat(OP_CLEAR, KEY_W'($urandom), $urandom);
      end else begin
        send_beat(op_t'($urandom_range(3)), KEY_W'($urandom), $urandom);
      end
    end
  endtask

  // Fill the table, then push new keys against it while freeing slots
  task automatic test_capacity(int n);
    logic [KEY_W-1:0] key;
    int               start;
    int               roll;
    start = beats_sent;
    while (beats_sent - start < n) begin
      send_beat(OP_CLEAR, KEY_W'($urandom), $urandom);
      for (int k = 0; k < ENTRIES; k++) begin
        do key = KEY_W'($urandom_range(16'hFFFF, 1)); while (find_entry(key) >= 0);
        send_beat(OP_ADD, key, pick_amount());
      end
      for (int k = 0; k < 10; k++) begin
        roll = $urandom_range(3);
        if (roll < 2)
          send_beat(OP_ADD, KEY_W'($urandom_range(16'hFFFF, 1)), pick_amount());
        else if (roll == 2)
          send_beat(OP_ADD, pick_held_key(), pick_amount());
        else
          send_beat(OP_REMOVE, pick_held_key(), $urandom_range(32'h7FFF_FFFF, 1));
      end
    end
  endtask

  // Unconstrained fields, including zero keys, negative amounts and code 3
  task automatic test_noise(int n);
    logic [KEY_W-1:0] key;
    logic [31:0]      amt;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0:       key = '0;
        1, 2, 3: key = pick_held_key();
        default: key = KEY_W'($urandom);
      endcase
      amt = ($urandom_range(2) == 0) ? pick_amount() : $urandom;
      send_beat(op_t'($urandom_range(3)), key, amt);
    end
  endtask

  // Result sink with random back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Compare each result beat with the oldest expected reply
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (table_replies.size() == 0) begin
        $error("unexpected result beat: status %0d count_after %0h", out_ch.status,
               out_ch.count_after);
        err_count++;
      end else begin
        want_reply = table_replies.pop_front();
        if (out_ch.status !== want_reply.status) begin
          $error("status: expected %0d, got %0d", want_reply.status, out_ch.status);
          err_count++;
        end
        if (out_ch.count_after !== want_reply.count_after) begin
          $error("count_after: expected %0h, got %0h", want_reply.count_after,
                 out_ch.count_after);
          err_count++;
        end
        if (out_ch.saturated !== want_reply.saturated) begin
          $error("saturated: expected %0b, got %0b", want_reply.saturated, out_ch.saturated);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_keyed_count_table: errors");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    send_gap_pct     = 37;
    recv_gap_pct     = 67;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_ADD;
    in_ch.key_tag   <= '0;
    in_ch.amount    <= '0;
    foreach (tbl_used[i]) begin
      tbl_used[i]  = 1'b0;
      tbl_key[i]   = '0;
      tbl_count[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_gap_pct = 37; recv_gap_pct = 67; end
        1: begin send_gap_pct = 67; recv_gap_pct = 37; end
        default: begin send_gap_pct = 0; recv_gap_pct = 0; end
      endcase
      test_churn(300);
      test_capacity(200);
      test_noise(115);
    end

    wait_replies();
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0)
      $display("tb_keyed_count_table: clean");
    else
      $display("tb_keyed_count_table: errors");
    $finish;
  end

endmodule
